// ===== design/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared constants, register codes and types for the framebuffer scanout
// address block.
// ----------------------------------------------------------------------------
package fsa_pkg;

    // Width of the region scan window in video clocks.
    localparam int unsigned SCAN_WIDTH = 640;

    // Region scan window origins and heights.
    localparam logic [9:0] NTSC_HSTART = 10'd108;
    localparam logic [9:0] PAL_HSTART  = 10'd128;
    localparam logic [9:0] NTSC_VSTART = 10'd34;
    localparam logic [9:0] PAL_VSTART  = 10'd44;
    localparam logic [9:0] NTSC_VLEN   = 10'd480;
    localparam logic [9:0] PAL_VLEN    = 10'd576;

    // Fixed-point fraction widths of the vertical and horizontal source positions.
    localparam int unsigned Y_FRAC_SHIFT = 11;
    localparam int unsigned X_FRAC_SHIFT = 10;

    // Widest configuration register.
    localparam int unsigned CFG_DATA_W = 28;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ORIGIN_ADDRESS = 3'd0,
        CFG_LINE_PITCH     = 3'd1,
        CFG_H_VIDEO        = 3'd2,
        CFG_V_VIDEO        = 3'd3,
        CFG_X_SCALE        = 3'd4,
        CFG_Y_SCALE        = 3'd5,
        CFG_COLOR_MODE     = 3'd6,
        CFG_PAL_MODE       = 3'd7
    } cfg_index_t;

    // Color modes; the two lower codes are blank.
    localparam logic [1:0] COLOR_15BPP = 2'd2;
    localparam logic [1:0] COLOR_24BPP = 2'd3;

    // Item kinds.
    localparam logic KIND_LOCATE  = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    // Configuration register file contents.
    typedef struct packed {
        logic [23:0] origin_address;
        logic [11:0] line_pitch;
        logic [25:0] h_video;
        logic [25:0] v_video;
        logic [27:0] x_scale;
        logic [27:0] y_scale;
        logic [1:0]  color_mode;
        logic        pal_mode;
    } cfg_t;

    // Widens a 5-bit color channel to 8 bits by bit replication.
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

// ===== design/fsa_regs.sv =====
// ----------------------------------------------------------------------------
// fsa_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module fsa_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [fsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fsa_pkg::cfg_t                     cfg
);

    fsa_pkg::cfg_t cfg_reg;
    fsa_pkg::cfg_t cfg_next;

    // Writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (fsa_pkg::cfg_index_t'(cfg_index))
                fsa_pkg::CFG_ORIGIN_ADDRESS: cfg_next.origin_address = cfg_data[23:0];
                fsa_pkg::CFG_LINE_PITCH:     cfg_next.line_pitch     = cfg_data[11:0];
                fsa_pkg::CFG_H_VIDEO:        cfg_next.h_video        = cfg_data[25:0];
                fsa_pkg::CFG_V_VIDEO:        cfg_next.v_video        = cfg_data[25:0];
                fsa_pkg::CFG_X_SCALE:        cfg_next.x_scale        = cfg_data[27:0];
                fsa_pkg::CFG_Y_SCALE:        cfg_next.y_scale        = cfg_data[27:0];
                fsa_pkg::CFG_COLOR_MODE:     cfg_next.color_mode     = cfg_data[1:0];
                fsa_pkg::CFG_PAL_MODE:       cfg_next.pal_mode       = cfg_data[0];
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/fsa_pipe.sv =====
// ----------------------------------------------------------------------------
// fsa_pipe
// Four-stage locate and convert datapath with per-stage valid bits and stall.
// ----------------------------------------------------------------------------
module fsa_pipe (
    input  logic           aclk,
    input  logic           aresetn,
    input  fsa_pkg::cfg_t  cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_kind,
    input  logic [9:0]     s_screen_x,
    input  logic [9:0]     s_screen_y,
    input  logic           s_field,
    input  logic [31:0]    s_pixel_word,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_visible,
    output logic [31:0]    m_fetch_address,
    output logic [9:0]     m_out_x,
    output logic [9:0]     m_out_y,
    output logic [7:0]     m_red,
    output logic [7:0]     m_green,
    output logic [7:0]     m_blue
);

    typedef struct packed {
        logic       vis;
        logic [9:0] out_x;
        logic [9:0] out_y;
        logic [9:0] dx;
        logic [9:0] dy;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } st1_t;

    typedef struct packed {
        logic        vis;
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [21:0] y0;
        logic [21:0] x0;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } st2_t;

    typedef struct packed {
        logic        vis;
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [22:0] row_off;
        logic [11:0] col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } st3_t;

    typedef struct packed {
        logic        vis;
        logic [31:0] addr;
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } st4_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    logic en1, en2, en3, en4;

    // Stage 1 window terms.
    logic [9:0]  hs0, vs0, vlen, hstart, hend, dx0;
    logic [10:0] hs1, vs1, vstart, vend, dx1, dy0, dy1, dy_full;
    logic        vis1;

    // Stage 4 byte offsets.
    logic [24:0] row_bytes;
    logic [13:0] col_bytes;

    // A stage takes a new item when it is empty or its item moves on.
    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign v1_next = en1 ? s_valid : v1_reg;
    assign v2_next = en2 ? v1_reg  : v2_reg;
    assign v3_next = en3 ? v2_reg  : v3_reg;
    assign v4_next = en4 ? v3_reg  : v4_reg;

    // Stage 1: active window test, coordinates and pixel conversion.
    always_comb begin
        hs0    = cfg.pal_mode ? fsa_pkg::PAL_HSTART : fsa_pkg::NTSC_HSTART;
        vs0    = cfg.pal_mode ? fsa_pkg::PAL_VSTART : fsa_pkg::NTSC_VSTART;
        vlen   = cfg.pal_mode ? fsa_pkg::PAL_VLEN   : fsa_pkg::NTSC_VLEN;
        hs1    = {1'b0, hs0} + 11'(fsa_pkg::SCAN_WIDTH);
        vs1    = {1'b0, vs0} + {1'b0, vlen};
        hstart = cfg.h_video[25:16];
        hend   = cfg.h_video[9:0];
        vstart = {1'b0, cfg.v_video[25:16]} + {9'd0, s_field, 1'b0};
        vend   = {1'b0, cfg.v_video[9:0]}   + {9'd0, s_field, 1'b0};
        dx0    = (hs0 > hstart) ? hs0 : hstart;
        dx1    = (hs1 < {1'b0, hend}) ? hs1 : {1'b0, hend};
        dy0    = ({1'b0, vs0} > vstart) ? {1'b0, vs0} : vstart;
        dy1    = (vs1 < vend) ? vs1 : vend;
        vis1   = cfg.color_mode[1]
              && (s_screen_x >= dx0) && ({1'b0, s_screen_x} < dx1)
              && ({1'b0, s_screen_y} >= dy0) && ({1'b0, s_screen_y} < dy1);
        dy_full = {1'b0, s_screen_y} - vstart;

        s1_next = s1_reg;
        if (en1 && s_valid) begin
            s1_next = '0;
            if (s_kind == fsa_pkg::KIND_CONVERT) begin
                case (cfg.color_mode)
                    fsa_pkg::COLOR_15BPP: begin
                        s1_next.red   = fsa_pkg::widen5(s_pixel_word[15:11]);
                        s1_next.green = fsa_pkg::widen5(s_pixel_word[10:6]);
                        s1_next.blue  = fsa_pkg::widen5(s_pixel_word[5:1]);
                    end
                    fsa_pkg::COLOR_24BPP: begin
                        s1_next.red   = s_pixel_word[31:24];
                        s1_next.green = s_pixel_word[23:16];
                        s1_next.blue  = s_pixel_word[15:8];
                    end
                    default: begin
                        s1_next.red   = 8'd0;
                        s1_next.green = 8'd0;
                        s1_next.blue  = 8'd0;
                    end
                endcase
            end else begin
                s1_next.vis   = vis1;
                s1_next.out_x = s_screen_x - hs0;
                s1_next.out_y = s_screen_y - vs0;
                s1_next.dx    = s_screen_x - hstart;
                s1_next.dy    = dy_full[9:0];
            end
        end
    end

    // Stage 2: fixed-point source positions.
    always_comb begin
        s2_next = s2_reg;
        if (en2 && v1_reg) begin
            s2_next.vis   = s1_reg.vis;
            s2_next.out_x = s1_reg.out_x;
            s2_next.out_y = s1_reg.out_y;
            s2_next.red   = s1_reg.red;
            s2_next.green = s1_reg.green;
            s2_next.blue  = s1_reg.blue;
            s2_next.y0    = {10'd0, cfg.y_scale[27:16]} + (cfg.y_scale[11:0] * s1_reg.dy);
            s2_next.x0    = {10'd0, cfg.x_scale[27:16]} + (cfg.x_scale[11:0] * s1_reg.dx);
        end
    end

    // Stage 3: source row times line pitch, source column.
    always_comb begin
        s3_next = s3_reg;
        if (en3 && v2_reg) begin
            s3_next.vis     = s2_reg.vis;
            s3_next.out_x   = s2_reg.out_x;
            s3_next.out_y   = s2_reg.out_y;
            s3_next.red     = s2_reg.red;
            s3_next.green   = s2_reg.green;
            s3_next.blue    = s2_reg.blue;
            s3_next.row_off = s2_reg.y0[21:fsa_pkg::Y_FRAC_SHIFT] * cfg.line_pitch;
            s3_next.col     = s2_reg.x0[21:fsa_pkg::X_FRAC_SHIFT];
        end
    end

    // Stage 4: byte address, scaled by 4 bytes per pixel in 24bpp, else 2.
    always_comb begin
        row_bytes = cfg.color_mode[0] ? {s3_reg.row_off, 2'b00} : {1'b0, s3_reg.row_off, 1'b0};
        col_bytes = cfg.color_mode[0] ? {s3_reg.col, 2'b00}     : {1'b0, s3_reg.col, 1'b0};
        s4_next = s4_reg;
        if (en4 && v3_reg) begin
            s4_next.vis   = s3_reg.vis;
            s4_next.out_x = s3_reg.out_x;
            s4_next.out_y = s3_reg.out_y;
            s4_next.red   = s3_reg.red;
            s4_next.green = s3_reg.green;
            s4_next.blue  = s3_reg.blue;
            s4_next.addr  = s3_reg.vis
                          ? ({8'd0, cfg.origin_address} + {7'd0, row_bytes} + {18'd0, col_bytes})
                          : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
    end

    assign m_valid         = v4_reg;
    assign m_visible       = s4_reg.vis;
    assign m_fetch_address = s4_reg.addr;
    assign m_out_x         = s4_reg.out_x;
    assign m_out_y         = s4_reg.out_y;
    assign m_red           = s4_reg.red;
    assign m_green         = s4_reg.green;
    assign m_blue          = s4_reg.blue;

    // A visible result comes from a locate item and carries no color.
    a_visible_no_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && s4_reg.vis) |-> (s4_reg.red == 8'd0 && s4_reg.green == 8'd0
                                    && s4_reg.blue == 8'd0))
        else $error("visible result carries color");

    // Only drawing modes mark a position visible.
    a_vis_needs_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && s1_reg.vis) |-> cfg.color_mode[1])
        else $error("visible position in blank mode");

    // An item that leaves stage 2 arrives in stage 3 unchanged in visibility.
    a_stage3_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && en3) |=> (v3_reg && s3_reg.vis == $past(s2_reg.vis)))
        else $error("item lost between stages 2 and 3");

    // A stalled output item stays in place.
    a_output_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_ready) |=> (v4_reg && $stable(s4_reg)))
        else $error("stalled result changed");

endmodule

// ===== design/framebuffer_scanout_address.sv =====
// ----------------------------------------------------------------------------
// framebuffer_scanout_address
// Framebuffer scanout locator and pixel converter, top level.
// ----------------------------------------------------------------------------
// Each accepted input item yields exactly one result item, and a new item can
// be accepted in every cycle unless the result channel holds the flow: the
// datapath is a four-stage pipeline (window test and color conversion,
// fixed-point source position multiply, row-times-pitch multiply, address sum)
// whose valid bits travel with the data. Back-pressure on the result channel
// stalls the pipeline stage by stage, so bubbles are squeezed out and no item
// is lost or repeated. Configuration registers are written through their own
// channel, which is always ready; a write takes effect on the next cycle and
// should be issued only while no items are in flight.
// ----------------------------------------------------------------------------
module framebuffer_scanout_address (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [fsa_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input item channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [9:0]                      s_screen_x,
    input  logic [9:0]                      s_screen_y,
    input  logic                            s_field,
    input  logic [31:0]                     s_pixel_word,
    // Result item channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_visible,
    output logic [31:0]                     m_fetch_address,
    output logic [9:0]                      m_out_x,
    output logic [9:0]                      m_out_y,
    output logic [7:0]                      m_red,
    output logic [7:0]                      m_green,
    output logic [7:0]                      m_blue
);

    // Current register contents, shared by every pipeline stage.
    fsa_pkg::cfg_t cfg;

    fsa_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The pipeline reads the registers directly; the user must hold them still
    // while items are in flight, as the block itself does not enforce it.
    fsa_pipe u_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_screen_x      (s_screen_x),
        .s_screen_y      (s_screen_y),
        .s_field         (s_field),
        .s_pixel_word    (s_pixel_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_visible       (m_visible),
        .m_fetch_address (m_fetch_address),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue)
    );

endmodule
